// ===== hw/rtl/asci_pkg.sv =====
// Shared types and constants for the audio sample counter interrupt unit.
// Used by asci_core and audio_sample_counter_irq_unit; no dependencies.
`default_nettype none

package asci_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned IdxW  = 3;
	localparam int unsigned TbW   = 27;
	localparam int unsigned CtlW  = 7;

	localparam logic [TbW-1:0] TbReset = 27'd60750000;
	localparam logic [TbW-1:0] RateHi  = 27'd48000;
	localparam logic [TbW-1:0] RateLo  = 27'd32000;

	localparam logic [CtlW-1:0] CtlPstat   = 7'h01;
	localparam logic [CtlW-1:0] CtlAisfr   = 7'h02;
	localparam logic [CtlW-1:0] CtlIntMsk  = 7'h04;
	localparam logic [CtlW-1:0] CtlInt     = 7'h08;
	localparam logic [CtlW-1:0] CtlIntVld  = 7'h10;
	localparam logic [CtlW-1:0] CtlScReset = 7'h20;
	localparam logic [CtlW-1:0] CtlAidfr   = 7'h40;
	localparam logic [CtlW-1:0] CtlKept    =
		CtlPstat | CtlAisfr | CtlIntMsk | CtlIntVld | CtlAidfr;

	localparam logic [IdxW-1:0] RegControl = 3'd0;
	localparam logic [IdxW-1:0] RegVolume  = 3'd1;
	localparam logic [IdxW-1:0] RegCount   = 3'd2;
	localparam logic [IdxW-1:0] RegTarget  = 3'd3;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IdxW-1:0]  idx;
		logic [DataW-1:0] data;
	} asci_req_t;

	typedef struct packed {
		logic [DataW-1:0] read_data;
		logic             irq;
		logic             dac_48k;
	} asci_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/audio_sample_counter_irq_unit.sv =====
// Top level of the audio sample counter interrupt unit: request and result
// registers around asci_core. Depends on asci_pkg and asci_core.
//
// Usage: each request on the in channel (operation, reg_index, write_data)
// is a register read, a register write, one timebase tick or a no-op.
// Every request yields exactly one result on the out channel (read_data,
// irq_line, dac_is_48k), in request order.
// A request passes through the request register, then the result register,
// before out_valid rises. Throughput: one request per cycle while the receiver
// does not stall, set by the single state update that the phase add and count
// compare make per request.
// cfg_we writes timebase_hz from cfg_wdata; write it only while idle.
// Reset clears the core state and valid flags, sets timebase_hz to 60750000
// and empties the pipeline. When the receiver stalls, the result holds in its
// register and the request register still fills, after which in_ready drops.
`default_nettype none

module audio_sample_counter_irq_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [asci_pkg::TbW-1:0]   cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 operation,
	input  wire logic [asci_pkg::IdxW-1:0]  reg_index,
	input  wire logic [asci_pkg::DataW-1:0] write_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [asci_pkg::DataW-1:0]      read_data,
	output logic                            irq_line,
	output logic                            dac_is_48k
);

	logic                valid_s1;
	asci_pkg::asci_req_t req_s1;
	asci_pkg::asci_rsp_t rsp;
	asci_pkg::asci_rsp_t rsp_s2;
	logic                advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1.op   <= asci_pkg::op_t'(operation);
			req_s1.idx  <= reg_index;
			req_s1.data <= write_data;
		end
	end

	asci_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_fire  (advance),
		.req       (req_s1),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp;
		end
	end

	assign read_data  = rsp_s2.read_data;
	assign irq_line   = rsp_s2.irq;
	assign dac_is_48k = rsp_s2.dac_48k;

endmodule

`default_nettype wire

// ===== hw/rtl/asci_core.sv =====
// Register file, phase accumulator and sample counter of the interrupt unit.
// Depends on asci_pkg; the response is combinational from state and request.
`default_nettype none

module asci_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [asci_pkg::TbW-1:0]  cfg_wdata,
	input  wire logic                      req_fire,
	input  wire asci_pkg::asci_req_t       req,
	output asci_pkg::asci_rsp_t            rsp
);

	logic [asci_pkg::TbW-1:0]   timebase_q;
	logic [asci_pkg::CtlW-1:0]  control_q, control_d;
	logic [asci_pkg::DataW-1:0] volume_q, volume_d;
	logic [asci_pkg::DataW-1:0] count_q, count_d;
	logic [asci_pkg::DataW-1:0] target_q, target_d;
	logic [asci_pkg::TbW-1:0]   phase_q, phase_d;

	logic [asci_pkg::TbW-1:0]   div;
	logic [asci_pkg::TbW-1:0]   rate;
	logic [asci_pkg::TbW:0]     psum;
	logic [asci_pkg::TbW:0]     pdiff;
	logic [asci_pkg::DataW-1:0] count_inc;
	logic [asci_pkg::DataW-1:0] rd;

	assign div  = (timebase_q < asci_pkg::RateHi) ? asci_pkg::RateHi : timebase_q;
	assign rate = ((control_q & asci_pkg::CtlAisfr) != '0) ? asci_pkg::RateHi
		: asci_pkg::RateLo;
	assign psum      = {1'b0, phase_q} + {1'b0, rate};
	assign pdiff     = psum - {1'b0, div};
	assign count_inc = count_q + 32'd1;

	always_comb begin
		control_d = control_q;
		volume_d  = volume_q;
		count_d   = count_q;
		target_d  = target_q;
		phase_d   = phase_q;
		rd        = '0;
		unique case (req.op)
			asci_pkg::OP_READ: begin
				case (req.idx)
					asci_pkg::RegControl: rd = {{(asci_pkg::DataW-asci_pkg::CtlW){1'b0}},
						control_q};
					asci_pkg::RegVolume:  rd = volume_q;
					asci_pkg::RegCount:   rd = count_q;
					asci_pkg::RegTarget:  rd = target_q;
					default:              rd = '0;
				endcase
			end
			asci_pkg::OP_WRITE: begin
				case (req.idx)
					asci_pkg::RegControl: begin
						control_d = (req.data[asci_pkg::CtlW-1:0] & asci_pkg::CtlKept)
							| (control_q & asci_pkg::CtlInt
							& ~(req.data[asci_pkg::CtlW-1:0] & asci_pkg::CtlInt));
						phase_d = '0;
						if ((req.data[asci_pkg::CtlW-1:0] & asci_pkg::CtlScReset) != '0) begin
							count_d = '0;
						end
					end
					asci_pkg::RegVolume: volume_d = req.data;
					asci_pkg::RegCount: begin
						count_d = req.data;
						phase_d = '0;
					end
					asci_pkg::RegTarget: target_d = req.data;
					default: ;
				endcase
			end
			asci_pkg::OP_TICK: begin
				if ((control_q & asci_pkg::CtlPstat) != '0) begin
					if (psum >= {1'b0, div}) begin
						phase_d = pdiff[asci_pkg::TbW-1:0];
						count_d = count_inc;
						if (count_inc == target_q) begin
							control_d = control_q | asci_pkg::CtlInt;
						end
					end else begin
						phase_d = psum[asci_pkg::TbW-1:0];
					end
				end
			end
			default: ;
		endcase
		rsp.read_data = rd;
		rsp.irq       = ((control_d & asci_pkg::CtlInt) != '0)
			&& ((control_d & asci_pkg::CtlIntMsk) != '0);
		rsp.dac_48k   = (control_d & asci_pkg::CtlAidfr) == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timebase_q <= asci_pkg::TbReset;
		end else if (cfg_we) begin
			timebase_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			volume_q  <= '0;
			count_q   <= '0;
			target_q  <= '0;
			phase_q   <= '0;
		end else if (req_fire) begin
			control_q <= control_d;
			volume_q  <= volume_d;
			count_q   <= count_d;
			target_q  <= target_d;
			phase_q   <= phase_d;
		end
	end

endmodule

`default_nettype wire

// ===== tb/asci_sample_checker.sv =====
// Checker for the audio sample counter interrupt unit: tracks the register,
// phase and count state from the accepted requests and compares each result.
// Depends on asci_pkg.
`timescale 1ns / 100ps

module asci_sample_checker
	import asci_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [TbW-1:0]   cfg_wdata,
	input  wire logic             in_valid,
	input  wire logic             in_ready,
	input  wire logic [1:0]       operation,
	input  wire logic [IdxW-1:0]  reg_index,
	input  wire logic [DataW-1:0] write_data,
	input  wire logic             out_valid,
	input  wire logic             out_ready,
	input  wire logic [DataW-1:0] read_data,
	input  wire logic             irq_line,
	input  wire logic             dac_is_48k,
	output int unsigned           due_count,
	output int unsigned           mismatch_count
);

	logic [TbW-1:0]   timebase;
	logic [CtlW-1:0]  ctl;
	logic [DataW-1:0] volume;
	logic [DataW-1:0] count;
	logic [DataW-1:0] target;
	logic [TbW-1:0]   phase;
	asci_rsp_t        due_rsp_q[$];

	function automatic asci_rsp_t apply_request(op_t op, logic [IdxW-1:0] idx,
			logic [DataW-1:0] data);
		asci_rsp_t       rsp;
		logic [CtlW-1:0] held_int;
		logic [31:0]     divisor;
		logic [31:0]     rate;
		logic [31:0]     acc;
		rsp = '0;
		case (op)
			OP_READ: begin
				case (idx)
					RegControl: rsp.read_data = 32'(ctl);
					RegVolume:  rsp.read_data = volume;
					RegCount:   rsp.read_data = count;
					RegTarget:  rsp.read_data = target;
					default:    rsp.read_data = '0;
				endcase
			end
			OP_WRITE: begin
				case (idx)
					RegControl: begin
						held_int = ctl & CtlInt & ~(data[CtlW-1:0] & CtlInt);
						ctl = (data[CtlW-1:0] & CtlKept) | held_int;
						phase = '0;
						if (|(data[CtlW-1:0] & CtlScReset))
							count = '0;
					end
					RegVolume: volume = data;
					RegCount: begin
						count = data;
						phase = '0;
					end
					RegTarget: target = data;
					default: ;
				endcase
			end
			OP_TICK: begin
				if (|(ctl & CtlPstat)) begin
					divisor = (timebase < RateHi) ? 32'(RateHi) : 32'(timebase);
					rate = (|(ctl & CtlAisfr)) ? 32'(RateHi) : 32'(RateLo);
					acc = 32'(phase) + rate;
					if (acc >= divisor) begin
						acc = acc - divisor;
						count = count + 1;
						if (count == target)
							ctl = ctl | CtlInt;
					end
					phase = acc[TbW-1:0];
				end
			end
			default: ;
		endcase
		rsp.irq = (|(ctl & CtlInt)) && (|(ctl & CtlIntMsk));
		rsp.dac_48k = ~|(ctl & CtlAidfr);
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		asci_rsp_t want;
		if (!arst_n) begin
			timebase = TbReset;
			ctl = '0;
			volume = '0;
			count = '0;
			target = '0;
			phase = '0;
			due_rsp_q.delete();
			due_count = 0;
			mismatch_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_rsp_q.size() == 0) begin
					$error("result with no request outstanding: read_data %h", read_data);
					mismatch_count++;
				end else begin
					want = due_rsp_q.pop_front();
					if (read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data, read_data);
						mismatch_count++;
					end
					if (irq_line !== want.irq) begin
						$error("irq_line: expected %b, got %b", want.irq, irq_line);
						mismatch_count++;
					end
					if (dac_is_48k !== want.dac_48k) begin
						$error("dac_is_48k: expected %b, got %b", want.dac_48k, dac_is_48k);
						mismatch_count++;
					end
				end
			end
			if (cfg_we)
				timebase = cfg_wdata;
			if (in_valid && in_ready)
				due_rsp_q.push_back(apply_request(op_t'(operation), reg_index, write_data));
			due_count = due_rsp_q.size();
		end
	end

endmodule

// ===== tb/audio_sample_counter_irq_unit_tb.sv =====
// Testbench top for audio_sample_counter_irq_unit: drives register accesses
// and ticks, stalls both channels, and reports the verdict of asci_sample_checker.
// Depends on asci_pkg, the unit under test and asci_sample_checker.
`timescale 1ns / 100ps

module audio_sample_counter_irq_unit_tb;
	import asci_pkg::*;

	localparam int unsigned    CycleLimit   = 500000;
	localparam int unsigned    HoldCycles   = 400;
	localparam int unsigned    PhaseItems   = 170;
	localparam logic [IdxW-1:0] RegUnmapLo  = 3'd4;
	localparam logic [IdxW-1:0] RegUnmapHi  = 3'd7;
	localparam logic [TbW-1:0] TbWidthMax   = '1;
	localparam logic [TbW-1:0] TbRangeMax   = 27'd100000000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [TbW-1:0]    cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        operation = '0;
	logic [IdxW-1:0]   reg_index = '0;
	logic [DataW-1:0]  write_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [DataW-1:0]  read_data;
	logic              irq_line;
	logic              dac_is_48k;
	int unsigned       due_count;
	int unsigned       mismatch_count;
	int unsigned       cycle_count = 0;
	int unsigned       items = 0;
	bit                idle_en = 1'b1;
	bit                long_hold = 1'b0;

	always #5 clk = ~clk;

	audio_sample_counter_irq_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.reg_index  (reg_index),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.irq_line   (irq_line),
		.dac_is_48k (dac_is_48k)
	);

	asci_sample_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.reg_index      (reg_index),
		.write_data     (write_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_data      (read_data),
		.irq_line       (irq_line),
		.dac_is_48k     (dac_is_48k),
		.due_count      (due_count),
		.mismatch_count (mismatch_count)
	);

	task automatic send(op_t op, logic [IdxW-1:0] idx, logic [DataW-1:0] data);
		if (idle_en && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		reg_index  <= idx;
		write_data <= data;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (due_count != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timebase(logic [TbW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_burst();
		logic [DataW-1:0] start;
		logic [DataW-1:0] ctl_word;
		int unsigned      kind;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			start = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
				: $urandom;
			send(OP_WRITE, RegCount, start);
			send(OP_WRITE, RegTarget, start + $urandom_range(1, 6));
			ctl_word = $urandom;
			if ($urandom_range(0, 6) != 0)
				ctl_word = ctl_word | 32'(CtlPstat);
			if ($urandom_range(0, 3) != 0)
				ctl_word = ctl_word & ~32'(CtlScReset);
			send(OP_WRITE, RegControl, ctl_word);
			repeat ($urandom_range(2, 14)) begin
				if ($urandom_range(0, 5) == 0)
					send(OP_READ, IdxW'($urandom_range(0, 3)), $urandom);
				else
					send(OP_TICK, IdxW'($urandom_range(0, 7)), $urandom);
			end
			send(OP_READ, RegControl, $urandom);
		end else if (kind < 8) begin
			repeat ($urandom_range(1, 6))
				send(op_t'($urandom_range(0, 3)), IdxW'($urandom_range(0, 7)), $urandom);
		end else begin
			repeat ($urandom_range(1, 4))
				send(op_t'($urandom_range(0, 1)), IdxW'($urandom_range(0, 3)), $urandom);
		end
	endtask

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				out_ready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		int unsigned phase_end;
		logic [TbW-1:0] tb_value;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_READ, RegControl, '0);
		send(OP_READ, RegVolume, $urandom);
		send(OP_READ, RegUnmapHi, '1);
		send(OP_WRITE, RegVolume, '1);
		send(OP_READ, RegVolume, '0);
		send(OP_WRITE, RegUnmapLo, '1);
		send(OP_NOP, RegUnmapHi, '1);
		send(OP_TICK, RegControl, '0);
		send(OP_WRITE, RegControl, 32'(CtlPstat));
		send(OP_TICK, RegControl, '0);
		drain();

		// timebase below the smallest allowed divisor
		write_timebase('0);
		send(OP_WRITE, RegControl, 32'(CtlKept));
		send(OP_WRITE, RegCount, 32'hFFFF_FFFE);
		send(OP_WRITE, RegTarget, 32'hFFFF_FFFF);
		send(OP_TICK, RegControl, '0);
		send(OP_TICK, RegControl, '0);
		send(OP_READ, RegControl, '0);
		send(OP_WRITE, RegControl, 32'(CtlInt | CtlScReset | CtlPstat));
		send(OP_READ, RegCount, '0);
		send(OP_WRITE, RegControl, '1);
		send(OP_WRITE, RegTarget, 32'd1);
		send(OP_TICK, RegControl, '0);
		send(OP_WRITE, RegControl, 32'(CtlPstat | CtlIntMsk));
		send(OP_READ, RegControl, '0);
		send(OP_WRITE, RegCount, '0);
		drain();

		// build up phase, then lower the timebase beneath it
		write_timebase(TbRangeMax);
		send(OP_WRITE, RegControl, 32'(CtlPstat));
		repeat (5) send(OP_TICK, RegControl, '0);
		drain();
		write_timebase(RateHi);
		repeat (5) send(OP_TICK, RegControl, '0);
		send(OP_READ, RegCount, '0);

		for (int ph = 0; ph < 10; ph++) begin
			drain();
			case (ph)
				0: tb_value = TbWidthMax;
				1: tb_value = RateHi;
				2: tb_value = TbW'($urandom_range(0, 47999));
				3: tb_value = TbRangeMax;
				6: tb_value = TbReset;
				default: tb_value = TbW'($urandom_range(48000, 150000));
			endcase
			write_timebase(tb_value);
			idle_en = (ph != 4) && (ph != 9);
			if (ph == 2)
				long_hold = 1'b1;
			phase_end = items + PhaseItems;
			while (items < phase_end)
				random_burst();
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
